/* src/rstbl_pkg.sv */
// Shared types, widths and codes for the reservation-station table.
// Used by rstbl_cell and reservation_station_table; depends on nothing else.
package rstbl_pkg;

  localparam int WORD_W = 32;
  localparam int TAG_W  = 3;
  localparam int OP_W   = 3;
  localparam int MODE_W = 2;
  localparam int CNT_W  = 3;

  localparam int ADD_STATIONS_DEF = 3;
  localparam int MUL_STATIONS_DEF = 2;

  localparam logic [MODE_W-1:0] MODE_ISSUE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BCAST    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd2;

  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADDI = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  typedef struct packed {
    logic              issue_en;
    logic              bcast_en;
    logic [OP_W-1:0]   op;
    logic              src1_ready;
    logic [WORD_W-1:0] src1_word;
    logic              src2_ready;
    logic [WORD_W-1:0] src2_word;
    logic [TAG_W-1:0]  cdb_tag;
    logic [WORD_W-1:0] cdb_value;
  } cell_cmd_t;

  typedef struct packed {
    logic             taken;
    logic [CNT_W-1:0] adders;
    logic [CNT_W-1:0] mults;
  } cell_chain_t;

  typedef struct packed {
    logic pick;
    logic sel;
  } cell_stat_t;

  function automatic logic op_is_add(input logic [OP_W-1:0] op);
    return (op == OP_ADD) || (op == OP_SUB) || (op == OP_ADDI);
  endfunction

  function automatic logic op_is_mul(input logic [OP_W-1:0] op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction

endpackage

/* src/reservation_station_table.sv */
// Top level of the reservation-station table: a row of station cells and the result register.
// Depends on rstbl_pkg and rstbl_cell.
//
// An issue beat gives one result; a broadcast beat gives none. In a dispatch scan the free unit
// counts ripple through the row of cells and pick the stations to send; the sends then leave
// one at a time, lowest station first, through the single result register, and each waits
// while the output is stalled. While sends are pending no new beat is accepted. After reset
// every station is free and the block is ready at once.
module reservation_station_table #(
  parameter int ADD_STATIONS = rstbl_pkg::ADD_STATIONS_DEF,
  parameter int MUL_STATIONS = rstbl_pkg::MUL_STATIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rstbl_pkg::MODE_W-1:0]       mode,
  input  logic [rstbl_pkg::OP_W-1:0]         op,
  input  logic                               src1_ready,
  input  logic [rstbl_pkg::WORD_W-1:0]       src1_word,
  input  logic                               src2_ready,
  input  logic [rstbl_pkg::WORD_W-1:0]       src2_word,
  input  logic [rstbl_pkg::TAG_W-1:0]        cdb_tag,
  input  logic [rstbl_pkg::WORD_W-1:0]       cdb_value,
  input  logic [rstbl_pkg::CNT_W-1:0]        free_adders,
  input  logic [rstbl_pkg::CNT_W-1:0]        free_multipliers,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               issued,
  output logic [rstbl_pkg::TAG_W-1:0]        station_tag,
  output logic                               dispatch_valid,
  output logic [rstbl_pkg::TAG_W-1:0]        dispatch_entry,
  output logic [rstbl_pkg::OP_W-1:0]         dispatch_op,
  output logic [rstbl_pkg::WORD_W-1:0]       operand_a,
  output logic [rstbl_pkg::WORD_W-1:0]       operand_b,
  output logic                               last
);
  import rstbl_pkg::*;

  localparam int TOTAL = ADD_STATIONS + MUL_STATIONS;
  localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  cell_cmd_t   cmd;
  cell_chain_t chain [TOTAL+1];
  cell_stat_t  stat  [TOTAL];
  logic [OP_W-1:0]   cell_op [TOTAL];
  logic [WORD_W-1:0] cell_a  [TOTAL];
  logic [WORD_W-1:0] cell_b  [TOTAL];
  logic [TOTAL-1:0]  clear_vec;
  logic [TOTAL-1:0]  sel_vec;
  logic [TOTAL-1:0]  pend;
  logic [TOTAL-1:0]  pend_rest;
  logic [IDX_W-1:0]  low_idx;
  logic [TAG_W-1:0]  pick_tag;
  logic              out_free;
  logic              emit;
  logic              accept;
  logic              issue_en;
  logic              scan_en;

  assign out_free = !out_valid || !out_stall;
  assign emit     = (pend != '0) && out_free;
  assign in_stall = (pend != '0) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign issue_en = accept && (mode == MODE_ISSUE);
  assign scan_en  = accept && (mode == MODE_DISPATCH);

  always_comb begin
    cmd.issue_en   = issue_en;
    cmd.bcast_en   = accept && (mode == MODE_BCAST);
    cmd.op         = op;
    cmd.src1_ready = src1_ready;
    cmd.src1_word  = src1_word;
    cmd.src2_ready = src2_ready;
    cmd.src2_word  = src2_word;
    cmd.cdb_tag    = cdb_tag;
    cmd.cdb_value  = cdb_value;
  end

  assign chain[0].taken  = 1'b0;
  assign chain[0].adders = free_adders;
  assign chain[0].mults  = free_multipliers;

  for (genvar g = 0; g < TOTAL; g++) begin : g_cell
    rstbl_cell #(
      .IS_MUL (g >= ADD_STATIONS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .clear       (clear_vec[g]),
      .chain_in    (chain[g]),
      .chain_out   (chain[g+1]),
      .stat        (stat[g]),
      .station_op  (cell_op[g]),
      .first_word  (cell_a[g]),
      .second_word (cell_b[g])
    );
    assign sel_vec[g]   = stat[g].sel;
    assign clear_vec[g] = emit && (low_idx == IDX_W'(g));
  end

  always_comb begin
    low_idx  = '0;
    pick_tag = '0;
    for (int i = TOTAL - 1; i >= 0; i--) begin
      if (pend[i]) begin
        low_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < TOTAL; i++) begin
      if (stat[i].pick) begin
        pick_tag = TAG_W'(i);
      end
    end
  end

  assign pend_rest = pend & (pend - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        pend      <= pend_rest;
      end else if (issue_en) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (scan_en) begin
        pend <= sel_vec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      issued         <= 1'b0;
      station_tag    <= '0;
      dispatch_valid <= 1'b1;
      dispatch_entry <= TAG_W'(low_idx);
      dispatch_op    <= cell_op[low_idx];
      operand_a      <= cell_a[low_idx];
      operand_b      <= cell_b[low_idx];
      last           <= (pend_rest == '0);
    end else if (issue_en) begin
      issued         <= chain[TOTAL].taken;
      station_tag    <= pick_tag;
      dispatch_valid <= 1'b0;
      dispatch_entry <= '0;
      dispatch_op    <= '0;
      operand_a      <= '0;
      operand_b      <= '0;
      last           <= 1'b1;
    end
  end

endmodule

/* src/rstbl_cell.sv */
// One reservation station of the table, with its link in the issue and scan chain.
// Depends on rstbl_pkg for the command, chain and status types.
module rstbl_cell #(
  parameter bit IS_MUL = 1'b0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rstbl_pkg::cell_cmd_t               cmd,
  input  logic                               clear,
  input  rstbl_pkg::cell_chain_t             chain_in,
  output rstbl_pkg::cell_chain_t             chain_out,
  output rstbl_pkg::cell_stat_t              stat,
  output logic [rstbl_pkg::OP_W-1:0]         station_op,
  output logic [rstbl_pkg::WORD_W-1:0]       first_word,
  output logic [rstbl_pkg::WORD_W-1:0]       second_word
);
  import rstbl_pkg::*;

  logic       station_free;
  logic       first_ready;
  logic       second_ready;
  logic       class_ok;
  logic       ready;
  logic [CNT_W-1:0] own_cnt;
  logic [WORD_W-1:0] tag_word;

  assign class_ok = IS_MUL ? op_is_mul(cmd.op) : op_is_add(cmd.op);
  assign ready    = !station_free && first_ready && second_ready;
  assign own_cnt  = IS_MUL ? chain_in.mults : chain_in.adders;
  assign tag_word = {{(WORD_W-TAG_W){1'b0}}, cmd.cdb_tag};

  always_comb begin
    stat.pick       = cmd.issue_en && class_ok && station_free && !chain_in.taken;
    stat.sel        = ready && (own_cnt != '0);
    chain_out.taken = chain_in.taken || stat.pick;
    chain_out.adders = chain_in.adders;
    chain_out.mults  = chain_in.mults;
    if (stat.sel) begin
      if (IS_MUL) begin
        chain_out.mults = chain_in.mults - 1'b1;
      end else begin
        chain_out.adders = chain_in.adders - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_free <= 1'b1;
    end else if (stat.pick) begin
      station_free <= 1'b0;
    end else if (clear) begin
      station_free <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.pick) begin
      station_op   <= cmd.op;
      first_ready  <= cmd.src1_ready;
      first_word   <= cmd.src1_ready ? cmd.src1_word
                                     : {{(WORD_W-TAG_W){1'b0}}, cmd.src1_word[TAG_W-1:0]};
      second_ready <= cmd.src2_ready;
      second_word  <= cmd.src2_ready ? cmd.src2_word
                                     : {{(WORD_W-TAG_W){1'b0}}, cmd.src2_word[TAG_W-1:0]};
    end else if (cmd.bcast_en) begin
      if (!first_ready && (first_word == tag_word)) begin
        first_ready <= 1'b1;
        first_word  <= cmd.cdb_value;
      end
      if (!second_ready && (second_word == tag_word)) begin
        second_ready <= 1'b1;
        second_word  <= cmd.cdb_value;
      end
    end
  end

endmodule
